@@ hw/rtl/i2cms_pkg.sv @@
// Package with the codes, field widths and defaults of the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam int DEFAULT_BUF_DEPTH = 32;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      REQ_START     = 2'd0,
      REQ_EVENT     = 2'd1,
      REQ_BUF_WRITE = 2'd2,
      REQ_BUF_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_WRITE       = 2'd0,
      KIND_READ        = 2'd1,
      KIND_SUB_WRITE   = 2'd2,
      KIND_RANDOM_READ = 2'd3
   } xfer_kind_type;

   typedef enum logic [1:0] {
      ST_START_SENT = 2'd0,
      ST_BYTE_SENT  = 2'd1,
      ST_BYTE_RECV  = 2'd2,
      ST_OTHER      = 2'd3
   } bus_status_type;

   // Shared by the START and STOP controls.
   typedef enum logic [1:0] {
      CTL_KEEP    = 2'd0,
      CTL_REQUEST = 2'd1,
      CTL_CLEAR   = 2'd2
   } cond_ctl_type;

   typedef enum logic [1:0] {
      ACK_KEEP = 2'd0,
      ACK_ACK  = 2'd1,
      ACK_NACK = 2'd2
   } ack_ctl_type;

endpackage

@@ hw/rtl/i2cms_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/i2c_master_transfer_sequencer.sv @@
// Top level of the I2C master transfer sequencer.
`timescale 1ns / 1ps
// The block sequences I2C master transfers: write, read, write at a subaddress
// and random read. Items arrive on the req_ channel: tuser says whether an item
// is a start command, a bus status event, a buffer write or a buffer read, and
// tdata carries the remaining fields. Every item gives exactly one result item
// on the rsp_ channel with the byte to transmit, the START, STOP and ACK
// controls, the bus reset flag, the busy flag and any buffer byte read back.
// An item is registered on acceptance while its buffer byte is read from the
// transfer buffer RAM; the decision logic then fills the result register from
// both, and the result is offered from there. One item is taken in every cycle
// while the receiver takes the results; the registered RAM read allows that.
// When the receiver stalls, the finished result waits in the result register
// and one further item waits in the input register; req_tready falls only when
// both are full. Reset clears the transfer state and empties both registers.
// The buffer contents are not cleared and are valid only once written.

module i2c_master_transfer_sequencer #(
   parameter int BUF_DEPTH = i2cms_pkg::DEFAULT_BUF_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_type
   input  logic [1:0]                       req_tuser,
   // xfer_kind, slave_address, sub_address, byte_count, bus_status, slave_ack,
   // arb_lost, rx_byte, buf_index, buf_value
   input  logic [i2cms_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cmd_ok, tx_valid, tx_byte, start_ctl, stop_ctl, ack_ctl, bus_reset,
   // busy_now, read_value
   output logic [i2cms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import i2cms_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

   // Input register.
   logic                  s1_valid_ff;
   logic [1:0]            s1_type_ff;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic                  rd_in_range_ff;
   logic                  fwd_hit_ff;
   logic [7:0]            fwd_data_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Transfer state.
   logic       busy_ff, busy_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] subaddr_ff, subaddr_in;
   logic       read_dir_ff, read_dir_in;
   logic       sub_pend_ff, sub_pend_in;
   logic       random_ff, random_in;
   logic       restart_ff, restart_in;
   logic [5:0] last_pos_ff, last_pos_in;
   logic [5:0] pos_ff, pos_in;

   logic advance;
   logic accept;

   // Fields of the registered item.
   xfer_kind_type  kind;
   bus_status_type status;
   logic [7:0]     saddr;
   logic [7:0]     sub;
   logic [5:0]     cnt;
   logic           ack;
   logic           arb;
   logic [7:0]     rxb;
   logic [4:0]     bidx;
   logic [7:0]     bval;

   logic [7:0] ram_q;
   logic [7:0] buf_byte;

   logic [7:0] wr_idx;
   logic       wr_in_range;
   logic       wr_en;
   logic [7:0] wr_data;
   logic [7:0] rd_idx;
   logic       rd_in_range;

   // Result fields.
   logic         cmd_ok;
   logic         tx_valid;
   logic [7:0]   tx_byte;
   cond_ctl_type start_ctl;
   cond_ctl_type stop_ctl;
   ack_ctl_type  ack_ctl;
   logic         bus_reset;
   logic [7:0]   read_value;
   logic         is_read;
   logic         fail;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign kind   = xfer_kind_type'(s1_data_ff[1:0]);
   assign saddr  = s1_data_ff[9:2];
   assign sub    = s1_data_ff[17:10];
   assign cnt    = s1_data_ff[23:18];
   assign status = bus_status_type'(s1_data_ff[25:24]);
   assign ack    = s1_data_ff[26];
   assign arb    = s1_data_ff[27];
   assign rxb    = s1_data_ff[35:28];
   assign bidx   = s1_data_ff[40:36];
   assign bval   = s1_data_ff[48:41];

   assign is_read = (kind == KIND_READ) || (kind == KIND_RANDOM_READ);

   // A write made by the previous item at the same edge as this item's read
   // is taken from the forwarding register rather than from the RAM.
   assign buf_byte = !rd_in_range_ff ? 8'd0 : (fwd_hit_ff ? fwd_data_ff : ram_q);

   always_comb begin
      busy_in     = busy_ff;
      target_in   = target_ff;
      subaddr_in  = subaddr_ff;
      read_dir_in = read_dir_ff;
      sub_pend_in = sub_pend_ff;
      random_in   = random_ff;
      restart_in  = restart_ff;
      last_pos_in = last_pos_ff;
      pos_in      = pos_ff;
      cmd_ok      = 1'b0;
      tx_valid    = 1'b0;
      tx_byte     = 8'd0;
      start_ctl   = CTL_KEEP;
      stop_ctl    = CTL_KEEP;
      ack_ctl     = ACK_KEEP;
      bus_reset   = 1'b0;
      read_value  = 8'd0;
      fail        = 1'b0;
      wr_idx      = 8'd0;
      wr_en       = 1'b0;
      wr_data     = bval;

      if (s1_valid_ff) begin
         unique case (req_kind_type'(s1_type_ff))
            REQ_START: begin
               if (!busy_ff && ({3'd0, cnt} <= DEPTH_W) && !(is_read && cnt == 6'd0)) begin
                  target_in   = saddr;
                  subaddr_in  = sub;
                  sub_pend_in = (kind == KIND_SUB_WRITE) || (kind == KIND_RANDOM_READ);
                  random_in   = (kind == KIND_RANDOM_READ);
                  read_dir_in = (kind == KIND_READ);
                  last_pos_in = is_read ? cnt - 6'd1 : cnt;
                  restart_in  = 1'b0;
                  busy_in     = 1'b1;
                  start_ctl   = CTL_REQUEST;
                  cmd_ok      = 1'b1;
               end
            end
            REQ_EVENT: begin
               if (arb) begin
                  fail = 1'b1;
               end else begin
                  unique case (status)
                     ST_START_SENT: begin
                        tx_valid  = 1'b1;
                        tx_byte   = {target_ff[7:1], read_dir_ff};
                        start_ctl = CTL_CLEAR;
                        pos_in    = 6'd0;
                     end
                     ST_BYTE_SENT: begin
                        priority if (!ack) begin
                           fail = 1'b1;
                        end else if (restart_ff) begin
                           restart_in = 1'b0;
                           start_ctl  = CTL_REQUEST;
                        end else if (sub_pend_ff) begin
                           sub_pend_in = 1'b0;
                           tx_valid    = 1'b1;
                           tx_byte     = subaddr_ff;
                           if (random_ff) begin
                              restart_in  = 1'b1;
                              read_dir_in = 1'b1;
                           end
                        end else if (!read_dir_ff) begin
                           if (pos_ff < last_pos_ff) begin
                              tx_valid = 1'b1;
                              tx_byte  = buf_byte;
                              pos_in   = pos_ff + 6'd1;
                           end else begin
                              stop_ctl = CTL_REQUEST;
                              busy_in  = 1'b0;
                           end
                        end
                     end
                     ST_BYTE_RECV: begin
                        wr_idx  = {2'd0, pos_ff};
                        wr_en   = 1'b1;
                        wr_data = rxb;
                        if (pos_ff < last_pos_ff) begin
                           ack_ctl = ACK_ACK;
                           pos_in  = pos_ff + 6'd1;
                        end else begin
                           busy_in  = 1'b0;
                           ack_ctl  = ACK_NACK;
                           stop_ctl = CTL_REQUEST;
                        end
                     end
                     ST_OTHER: begin
                        fail = 1'b1;
                     end
                  endcase
               end
               if (fail) begin
                  tx_valid   = 1'b0;
                  tx_byte    = 8'd0;
                  bus_reset  = 1'b1;
                  start_ctl  = CTL_CLEAR;
                  stop_ctl   = CTL_CLEAR;
                  ack_ctl    = ACK_NACK;
                  busy_in    = 1'b0;
                  restart_in = 1'b0;
               end
            end
            REQ_BUF_WRITE: begin
               wr_idx = {3'd0, bidx};
               wr_en  = 1'b1;
            end
            REQ_BUF_READ: begin
               read_value = buf_byte;
            end
         endcase
      end

      // State changes only when the item moves on into the result register.
      if (!advance) begin
         busy_in     = busy_ff;
         target_in   = target_ff;
         subaddr_in  = subaddr_ff;
         read_dir_in = read_dir_ff;
         sub_pend_in = sub_pend_ff;
         random_in   = random_ff;
         restart_in  = restart_ff;
         last_pos_in = last_pos_ff;
         pos_in      = pos_ff;
         wr_en       = 1'b0;
      end
   end

   assign wr_in_range = ({1'b0, wr_idx} < DEPTH_W);

   // The next item reads at the position that this cycle leaves behind.
   assign rd_idx = (req_kind_type'(req_tuser) == REQ_BUF_READ) ?
                   {3'd0, req_tdata[40:36]} : {2'd0, pos_in};
   assign rd_in_range = ({1'b0, rd_idx} < DEPTH_W);

   i2cms_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en && wr_in_range),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         target_ff    <= 8'd0;
         subaddr_ff   <= 8'd0;
         read_dir_ff  <= 1'b0;
         sub_pend_ff  <= 1'b0;
         random_ff    <= 1'b0;
         restart_ff   <= 1'b0;
         last_pos_ff  <= 6'd0;
         pos_ff       <= 6'd0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         busy_ff     <= busy_in;
         target_ff   <= target_in;
         subaddr_ff  <= subaddr_in;
         read_dir_ff <= read_dir_in;
         sub_pend_ff <= sub_pend_in;
         random_ff   <= random_in;
         restart_ff  <= restart_in;
         last_pos_ff <= last_pos_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff     <= req_tuser;
         s1_data_ff     <= req_tdata;
         rd_in_range_ff <= rd_in_range;
         fwd_hit_ff     <= wr_en && wr_in_range && (wr_idx == rd_idx);
         fwd_data_ff    <= wr_data;
      end
      if (advance) begin
         rsp_data_ff <= {6'd0, read_value, busy_in, bus_reset, ack_ctl, stop_ctl,
                         start_ctl, tx_byte, tx_valid, cmd_ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_reset_ends_transfer : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[16]) |-> !rsp_tdata[17])
      else $error("A failed transfer left the block busy.");

   a_cmd_requests_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[11:10] == CTL_REQUEST && rsp_tdata[17]))
      else $error("An accepted start command did not request START or set busy.");

   a_tx_byte_idle_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |-> (rsp_tdata[9:2] == 8'd0))
      else $error("A transmit byte was given without tx_valid.");

   a_stalled_item_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("The waiting input item was lost while the result was stalled.");
`endif

endmodule
